>>> sv/kufef_pkg.sv
// kufef_pkg: shared constants, types and the microcode rom for the kruskal edge filter
// no dependencies; used by kufef_ram users and kruskal_union_find_edge_filter

package kufef_pkg;

    // vertex count and derived widths
    localparam int VERTICES   = 1024;
    localparam int VERT_W     = $clog2(VERTICES);
    localparam int FIELD_W    = 10;
    localparam int WEIGHT_W   = 24;
    localparam int COST_W     = 32;
    localparam int RANK_W     = 4;
    localparam int RAM_W      = RANK_W + VERT_W;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;

    localparam logic [RANK_W-1:0] RANK_MAX     = RANK_W'(15);
    localparam logic [VERT_W-1:0] CLR_LAST_IDX = VERT_W'(VERTICES - 1);

    // program counter and step addresses
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_CLEAR    = PC_W'(0);
    localparam pc_t PC_IDLE     = PC_W'(1);
    localparam pc_t PC_READ     = PC_W'(2);
    localparam pc_t PC_WALK     = PC_W'(3);
    localparam pc_t PC_CP_START = PC_W'(4);
    localparam pc_t PC_CP_STEP  = PC_W'(5);
    localparam pc_t PC_SWITCH   = PC_W'(6);
    localparam pc_t PC_UNION    = PC_W'(7);
    localparam pc_t PC_BUMP     = PC_W'(8);
    localparam pc_t PC_EMIT     = PC_W'(9);
    localparam pc_t PC_LAST     = PC_EMIT;

    // datapath operation of one step
    typedef enum logic [3:0] {
        DP_CLEAR    = 4'd0,
        DP_LOAD     = 4'd1,
        DP_READ     = 4'd2,
        DP_WALK     = 4'd3,
        DP_CP_START = 4'd4,
        DP_CP_STEP  = 4'd5,
        DP_SWITCH   = 4'd6,
        DP_UNION    = 4'd7,
        DP_BUMP     = 4'd8,
        DP_EMIT     = 4'd9
    } dp_op_t;

    // jump conditions
    typedef enum logic [3:0] {
        COND_ALWAYS    = 4'd0,
        COND_CLR_LAST  = 4'd1,
        COND_ACCEPT    = 4'd2,
        COND_BAD       = 4'd3,
        COND_HIT       = 4'd4,
        COND_CUR_ROOT  = 4'd5,
        COND_NEXT_ROOT = 4'd6,
        COND_PHASE_B   = 4'd7,
        COND_NO_BUMP   = 4'd8,
        COND_OUT_FREE  = 4'd9
    } cond_t;

    // control word: when cond holds jump to target, else hold or fall through
    typedef struct packed {
        dp_op_t dp;
        cond_t  cond;
        pc_t    target;
        logic   hold;
    } uword_t;

    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t uw;
        unique case (pc)
            PC_CLEAR:    uw = '{DP_CLEAR,    COND_CLR_LAST,  PC_IDLE,     1'b1};
            PC_IDLE:     uw = '{DP_LOAD,     COND_ACCEPT,    PC_READ,     1'b1};
            PC_READ:     uw = '{DP_READ,     COND_BAD,       PC_EMIT,     1'b0};
            PC_WALK:     uw = '{DP_WALK,     COND_HIT,       PC_CP_START, 1'b1};
            PC_CP_START: uw = '{DP_CP_START, COND_CUR_ROOT,  PC_SWITCH,   1'b0};
            PC_CP_STEP:  uw = '{DP_CP_STEP,  COND_NEXT_ROOT, PC_SWITCH,   1'b1};
            PC_SWITCH:   uw = '{DP_SWITCH,   COND_PHASE_B,   PC_READ,     1'b0};
            PC_UNION:    uw = '{DP_UNION,    COND_NO_BUMP,   PC_EMIT,     1'b0};
            PC_BUMP:     uw = '{DP_BUMP,     COND_ALWAYS,    PC_EMIT,     1'b0};
            PC_EMIT:     uw = '{DP_EMIT,     COND_OUT_FREE,  PC_IDLE,     1'b1};
            default:     uw = '{DP_EMIT,     COND_ALWAYS,    PC_IDLE,     1'b0};
        endcase
        return uw;
    endfunction

    // endpoint lies inside the vertex range
    function automatic logic vertex_ok(input logic [FIELD_W-1:0] v);
        return 32'(v) < 32'(VERTICES);
    endfunction

endpackage

>>> sv/kufef_ram.sv
// kufef_ram: generic single-write, single-read ram with registered read data
// no dependencies

module kufef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/kruskal_union_find_edge_filter.sv
// Flow: each edge walks to the root of to_vertex, then of from_vertex, with path compression
// after each walk, then a join by rank and a rank bump on an equal-rank join; an out-of-range
// edge goes straight to the result; one ram read per hop or compression rewrite
// Throughput: one edge at a time; s_tready rises again in the cycle after the result is registered
// Reset: aresetn low, synchronous; a clearing pass over all VERTICES (1024) entries loads each
// parent entry with its own index and rank zero, s_tready held low; uses kufef_pkg, kufef_ram

module kruskal_union_find_edge_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kufef_pkg::S_TDATA_W-1:0] s_tdata,  // from_vertex, to_vertex, edge_weight
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kufef_pkg::M_TDATA_W-1:0] m_tdata   // accepted, total_cost
);

    localparam int VW = kufef_pkg::VERT_W;
    localparam int RW = kufef_pkg::RANK_W;
    localparam int FW = kufef_pkg::FIELD_W;

    // sequencer
    kufef_pkg::pc_t    pc_reg, pc_next;
    kufef_pkg::uword_t uw;
    logic              cond_true;

    // datapath registers
    logic [VW-1:0]                   clr_reg, clr_next;
    logic [VW-1:0]                   a_reg, a_next;
    logic [kufef_pkg::WEIGHT_W-1:0]  w_reg, w_next;
    logic [VW-1:0]                   root_reg, root_next;
    logic [VW-1:0]                   cur_reg, cur_next;
    logic [VW-1:0]                   rb_reg, rb_next;
    logic [RW-1:0]                   rank_x_reg, rank_x_next;
    logic [RW-1:0]                   rank_b_reg, rank_b_next;
    logic                            phase_b_reg, phase_b_next;
    logic                            bad_reg, bad_next;
    logic                            acc_reg, acc_next;
    logic [kufef_pkg::COST_W-1:0]    cost_reg, cost_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            m_acc_reg, m_acc_next;
    logic [kufef_pkg::COST_W-1:0]    m_cost_reg, m_cost_next;

    // ram signals
    logic                        ram_we;
    logic [VW-1:0]               ram_waddr;
    logic [kufef_pkg::RAM_W-1:0] ram_wdata;
    logic [VW-1:0]               ram_raddr;
    logic [kufef_pkg::RAM_W-1:0] ram_rdata;
    logic [VW-1:0]               rd_parent;
    logic [RW-1:0]               rd_rank;

    // input fields
    logic [FW-1:0]                  in_from;
    logic [FW-1:0]                  in_to;
    logic [kufef_pkg::WEIGHT_W-1:0] in_weight;

    logic [kufef_pkg::COST_W:0]  cost_sum;
    logic                        out_free;
    logic                        roots_differ;
    logic [RW-1:0]               rank_bumped;

    assign in_from   = s_tdata[FW-1:0];
    assign in_to     = s_tdata[2*FW-1:FW];
    assign in_weight = s_tdata[2*FW +: kufef_pkg::WEIGHT_W];

    assign rd_parent = ram_rdata[VW-1:0];
    assign rd_rank   = ram_rdata[VW +: RW];

    assign uw           = kufef_pkg::ucode_rom(pc_reg);
    assign out_free     = !m_valid_reg || m_tready;
    assign roots_differ = root_reg != rb_reg;
    assign cost_sum     = {1'b0, cost_reg} + (kufef_pkg::COST_W + 1)'(w_reg);
    assign rank_bumped  = (rank_x_reg == kufef_pkg::RANK_MAX) ? kufef_pkg::RANK_MAX
                                                               : rank_x_reg + RW'(1);

    // parent and rank per vertex, rank in the upper bits
    kufef_ram #(
        .WIDTH (kufef_pkg::RAM_W),
        .DEPTH (kufef_pkg::VERTICES)
    ) u_forest_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // jump condition select
    always_comb begin
        unique case (uw.cond)
            kufef_pkg::COND_ALWAYS:    cond_true = 1'b1;
            kufef_pkg::COND_CLR_LAST:  cond_true = clr_reg == kufef_pkg::CLR_LAST_IDX;
            kufef_pkg::COND_ACCEPT:    cond_true = s_tvalid;
            kufef_pkg::COND_BAD:       cond_true = bad_reg;
            kufef_pkg::COND_HIT:       cond_true = rd_parent == root_reg;
            kufef_pkg::COND_CUR_ROOT:  cond_true = cur_reg == root_reg;
            kufef_pkg::COND_NEXT_ROOT: cond_true = rd_parent == root_reg;
            kufef_pkg::COND_PHASE_B:   cond_true = phase_b_reg;
            kufef_pkg::COND_NO_BUMP:   cond_true = !(roots_differ && rank_x_reg == rank_b_reg);
            kufef_pkg::COND_OUT_FREE:  cond_true = out_free;
            default:                   cond_true = 1'b1;
        endcase
    end

    // step counter
    always_comb begin
        priority if (cond_true) begin
            pc_next = uw.target;
        end else if (uw.hold) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + kufef_pkg::PC_W'(1);
        end
    end

    assign s_tready = uw.dp == kufef_pkg::DP_LOAD;

    // datapath driven by the control word
    always_comb begin
        clr_next     = clr_reg;
        a_next       = a_reg;
        w_next       = w_reg;
        root_next    = root_reg;
        cur_next     = cur_reg;
        rb_next      = rb_reg;
        rank_x_next  = rank_x_reg;
        rank_b_next  = rank_b_reg;
        phase_b_next = phase_b_reg;
        bad_next     = bad_reg;
        acc_next     = acc_reg;
        cost_next    = cost_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_acc_next   = m_acc_reg;
        m_cost_next  = m_cost_reg;
        ram_we       = 1'b0;
        ram_waddr    = root_reg;
        ram_wdata    = {rank_x_reg, root_reg};
        ram_raddr    = root_reg;

        unique case (uw.dp)
            kufef_pkg::DP_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {RW'(0), clr_reg};
                clr_next  = clr_reg + VW'(1);
            end
            kufef_pkg::DP_LOAD: begin
                if (s_tvalid) begin
                    a_next       = VW'(in_from);
                    w_next       = in_weight;
                    root_next    = VW'(in_to);
                    cur_next     = VW'(in_to);
                    phase_b_next = 1'b1;
                    bad_next     = !(kufef_pkg::vertex_ok(in_from)
                                     && kufef_pkg::vertex_ok(in_to));
                    acc_next     = 1'b0;
                end
            end
            kufef_pkg::DP_READ: begin
                ram_raddr = root_reg;
            end
            // one hop up the parent chain per cycle
            kufef_pkg::DP_WALK: begin
                if (rd_parent == root_reg) begin
                    rank_x_next = rd_rank;
                end else begin
                    root_next = rd_parent;
                    ram_raddr = rd_parent;
                end
            end
            kufef_pkg::DP_CP_START: begin
                ram_raddr = cur_reg;
            end
            // point the current entry at the root, keep its rank, move on
            kufef_pkg::DP_CP_STEP: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = {rd_rank, root_reg};
                cur_next  = rd_parent;
                ram_raddr = rd_parent;
            end
            kufef_pkg::DP_SWITCH: begin
                if (phase_b_reg) begin
                    rb_next      = root_reg;
                    rank_b_next  = rank_x_reg;
                    root_next    = a_reg;
                    cur_next     = a_reg;
                    phase_b_next = 1'b0;
                end
            end
            // join by rank, root of from_vertex in root_reg
            kufef_pkg::DP_UNION: begin
                if (roots_differ) begin
                    acc_next  = 1'b1;
                    cost_next = cost_sum[kufef_pkg::COST_W] ? '1
                                                           : cost_sum[kufef_pkg::COST_W-1:0];
                    ram_we    = 1'b1;
                    if (rank_x_reg < rank_b_reg) begin
                        ram_waddr = root_reg;
                        ram_wdata = {rank_x_reg, rb_reg};
                    end else begin
                        ram_waddr = rb_reg;
                        ram_wdata = {rank_b_reg, root_reg};
                    end
                end
            end
            kufef_pkg::DP_BUMP: begin
                ram_we    = 1'b1;
                ram_waddr = root_reg;
                ram_wdata = {rank_bumped, root_reg};
            end
            kufef_pkg::DP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_acc_next   = acc_reg;
                    m_cost_next  = cost_reg;
                end
            end
            default: begin
                clr_next = clr_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= kufef_pkg::PC_CLEAR;
            clr_reg     <= '0;
            cost_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            clr_reg     <= clr_next;
            cost_reg    <= cost_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        w_reg       <= w_next;
        root_reg    <= root_next;
        cur_reg     <= cur_next;
        rb_reg      <= rb_next;
        rank_x_reg  <= rank_x_next;
        rank_b_reg  <= rank_b_next;
        phase_b_reg <= phase_b_next;
        bad_reg     <= bad_next;
        acc_reg     <= acc_next;
        m_acc_reg   <= m_acc_next;
        m_cost_reg  <= m_cost_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(kufef_pkg::M_TDATA_W - kufef_pkg::COST_W - 1)'(0),
                       m_cost_reg, m_acc_reg};

    // running cost never goes down
    a_cost_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> cost_reg >= $past(cost_reg))
        else $error("running cost decreased");

    // every parent written stays inside the vertex range
    a_parent_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> 32'(ram_wdata[VW-1:0]) < 32'(kufef_pkg::VERTICES))
        else $error("parent write outside vertex range");

    // compression never rewrites the root itself
    a_cp_not_root: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg == kufef_pkg::PC_CP_STEP |-> cur_reg != root_reg)
        else $error("compression step on root entry");

    // rank bump only after joining two distinct roots of equal rank
    a_bump_equal_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg == kufef_pkg::PC_BUMP |-> (rank_x_reg == rank_b_reg) && roots_differ)
        else $error("rank bump without equal-rank union");

    // step counter stays within the program
    a_pc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> pc_reg <= kufef_pkg::PC_LAST)
        else $error("step counter outside program");

endmodule
